// ===== hw/rtl/slfp_pkg.sv =====
// ----------------------------------------------------------------------------
// slfp_pkg
// Shared widths, register indexes and the control structs between the parser
// and the burst readout of the frame parser.
// ----------------------------------------------------------------------------
package slfp_pkg;

	localparam int BYTE_W        = 8;
	localparam int LEN_W         = 7;
	localparam int CFG_IDX_W     = 8;
	localparam int DEFAULT_DEPTH = 64;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 8'd1;

	localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'hAA;
	localparam logic [LEN_W-1:0]  MAX_LENGTH_RST = 7'd64;

	// payload write from the parser into the store
	typedef struct packed {
		logic              en;
		logic [BYTE_W-1:0] data;
	} wr_t;

	// burst launch after a good checksum
	typedef struct packed {
		logic             go;
		logic [LEN_W-1:0] len;
	} start_t;

endpackage

// ===== hw/rtl/slfp_burst.sv =====
// ----------------------------------------------------------------------------
// slfp_burst
// Payload store (one write port, one registered read port) and the readout
// engine that plays a stored frame out as a run of result items.
// ----------------------------------------------------------------------------
module slfp_burst #(
	parameter int PAYLOAD_DEPTH = slfp_pkg::DEFAULT_DEPTH,
	parameter int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  slfp_pkg::wr_t                wr,
	input  logic [AW-1:0]                wr_addr,
	input  slfp_pkg::start_t             start,
	output logic                         busy,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [slfp_pkg::BYTE_W-1:0]  out_byte,
	output logic [slfp_pkg::LEN_W-1:0]   out_len,
	output logic                         out_last,
	output logic                         out_empty
);

	logic [slfp_pkg::BYTE_W-1:0] mem [PAYLOAD_DEPTH];

	logic                       busy_q;
	logic                       empty_q;
	logic [slfp_pkg::LEN_W-1:0] len_q;
	logic [slfp_pkg::LEN_W-1:0] idx_q;

	logic                        pend_s1;
	logic [slfp_pkg::BYTE_W-1:0] rdata_s1;
	logic [slfp_pkg::LEN_W-1:0]  len_s1;
	logic                        last_s1;
	logic                        empty_s1;

	logic                        out_valid_q;
	logic [slfp_pkg::BYTE_W-1:0] out_byte_q;
	logic [slfp_pkg::LEN_W-1:0]  out_len_q;
	logic                        out_last_q;
	logic                        out_empty_q;

	logic issue;
	logic issue_last;

	// one read in flight at a time; issue only when the output slot frees up
	assign issue      = busy_q && !pend_s1 && (!out_valid_q || out_ready);
	assign issue_last = empty_q || (idx_q == (len_q - 7'd1));

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue && !empty_q) begin
			rdata_s1 <= mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			empty_q <= 1'b0;
			len_q   <= '0;
			idx_q   <= '0;
		end else if (start.go) begin
			busy_q  <= 1'b1;
			empty_q <= (start.len == '0);
			len_q   <= start.len;
			idx_q   <= '0;
		end else if (issue) begin
			idx_q <= idx_q + 7'd1;
			if (issue_last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			len_s1   <= len_q;
			last_s1  <= issue_last;
			empty_s1 <= empty_q;
		end
	end

	// slot is always free when read data lands (see issue condition)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			out_byte_q  <= empty_s1 ? '0 : rdata_s1;
			out_len_q   <= len_s1;
			out_last_q  <= last_s1;
			out_empty_q <= empty_s1;
		end
	end

	assign busy      = busy_q;
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_len   = out_len_q;
	assign out_last  = out_last_q;
	assign out_empty = out_empty_q;

`ifndef SYNTHESIS
	a_land_free: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !out_valid_q)
		else $error("read data landed on a full output slot");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_empty_q) |-> (out_last_q && out_len_q == '0))
		else $error("empty frame marker without last/zero length");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start.go |-> (!busy_q && !wr.en))
		else $error("burst launched while previous burst still reading");
`endif

endmodule

// ===== hw/rtl/sof_length_xor_frame_parser.sv =====
// ----------------------------------------------------------------------------
// sof_length_xor_frame_parser
// Start byte / length / payload / XOR checksum frame parser with buffered
// burst readout of good frames.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-----------------------------------------
//  s_*     | in  | s_tvalid / s_tready | s_tdata[7:0] rx_byte
//  m_*     | out | m_tvalid / m_tready | m_tdata payload_byte, frame_length;
//          |     |                     | m_tlast is_last; m_tuser frame_empty
//  cfg_*   | in  | cfg_valid/cfg_ready | cfg_index register, cfg_data value
//
//  Parsing takes one received item per cycle while s_tready is high;
//  s_tready is high unless a burst readout is running.
//  Readout of an n-byte frame: the single registered read port of the payload
//  store allows one read in flight at a time (read, then output register).
//  The input stalls from the checksum item until the last store read of the
//  burst is issued, so a new frame never overwrites unread payload.
//  m_tready low just holds the output register; reads wait for it.
//  Reset clears control state; the payload store is not cleared.
//  cfg_ready is always high; writes take effect the next cycle.
// ----------------------------------------------------------------------------
module sof_length_xor_frame_parser #(
	parameter int PAYLOAD_DEPTH = slfp_pkg::DEFAULT_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] rx_byte
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [15:0]                     m_tdata,   // [7:0] payload_byte,
	                                                   // [14:8] frame_length, [15] zero
	output logic                            m_tlast,   // is_last
	output logic                            m_tuser,   // [0] frame_empty
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [slfp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                      cfg_data
);

	localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
	localparam logic [slfp_pkg::LEN_W-1:0] DEPTH_LEN = slfp_pkg::LEN_W'(PAYLOAD_DEPTH);

	// parse phases
	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;
	localparam logic [1:0] PH_SUM  = 2'd3;

	logic [7:0]                 start_byte_q;
	logic [slfp_pkg::LEN_W-1:0] max_length_q;

	logic [1:0]                 ph_q;
	logic [slfp_pkg::LEN_W-1:0] exp_len_q;
	logic [slfp_pkg::LEN_W-1:0] idx_q;
	logic [7:0]                 xor_q;

	logic                       busy;
	logic                       accept;
	logic [slfp_pkg::LEN_W-1:0] eff_max;
	logic [slfp_pkg::LEN_W-1:0] idx_nxt;
	logic                       too_long;

	slfp_pkg::wr_t    wr;
	slfp_pkg::start_t start;

	logic                       out_valid;
	logic [7:0]                 out_byte;
	logic [slfp_pkg::LEN_W-1:0] out_len;
	logic                       out_last;
	logic                       out_empty;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= slfp_pkg::START_BYTE_RST;
			max_length_q <= slfp_pkg::MAX_LENGTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				slfp_pkg::REG_START_BYTE: start_byte_q <= cfg_data;
				slfp_pkg::REG_MAX_LENGTH: max_length_q <= cfg_data[slfp_pkg::LEN_W-1:0];
				default: ;  // unknown index: ignored
			endcase
		end
	end

	// longest accepted length: the configured maximum, capped at the store depth
	assign eff_max  = (max_length_q > DEPTH_LEN) ? DEPTH_LEN : max_length_q;
	assign too_long = (s_tdata > {1'b0, eff_max});

	// ---------------- parser ----------------
	assign s_tready = !busy;
	assign accept   = s_tvalid && s_tready;
	assign idx_nxt  = idx_q + 7'd1;

	assign wr.en    = accept && (ph_q == PH_DATA);
	assign wr.data  = s_tdata;

	assign start.go  = accept && (ph_q == PH_SUM) && (s_tdata == xor_q);
	assign start.len = exp_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q      <= PH_HUNT;
			exp_len_q <= '0;
			idx_q     <= '0;
			xor_q     <= '0;
		end else if (accept) begin
			case (ph_q)
				PH_HUNT: begin
					if (s_tdata == start_byte_q) begin
						ph_q <= PH_LEN;
					end
				end
				PH_LEN: begin
					// oversize length is consumed, not rechecked as a start byte
					if (too_long) begin
						ph_q <= PH_HUNT;
					end else begin
						exp_len_q <= s_tdata[slfp_pkg::LEN_W-1:0];
						idx_q     <= '0;
						xor_q     <= s_tdata;
						ph_q      <= (s_tdata == 8'd0) ? PH_SUM : PH_DATA;
					end
				end
				PH_DATA: begin
					xor_q <= xor_q ^ s_tdata;
					idx_q <= idx_nxt;
					if (idx_nxt >= exp_len_q) begin
						ph_q <= PH_SUM;
					end
				end
				default: begin
					// checksum item: match launches the burst, mismatch drops
					ph_q <= PH_HUNT;
				end
			endcase
		end
	end

	// ---------------- store and readout ----------------
	slfp_burst #(
		.PAYLOAD_DEPTH (PAYLOAD_DEPTH),
		.AW            (AW)
	) u_burst (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (wr),
		.wr_addr   (idx_q[AW-1:0]),
		.start     (start),
		.busy      (busy),
		.out_valid (out_valid),
		.out_ready (m_tready),
		.out_byte  (out_byte),
		.out_len   (out_len),
		.out_last  (out_last),
		.out_empty (out_empty)
	);

	assign m_tvalid = out_valid;
	assign m_tdata  = {1'b0, out_len, out_byte};
	assign m_tlast  = out_last;
	assign m_tuser  = out_empty;

`ifndef SYNTHESIS
	a_len_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_DATA || ph_q == PH_SUM) |-> (exp_len_q <= DEPTH_LEN))
		else $error("accepted length exceeds payload store depth");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_DATA) |-> (idx_q < exp_len_q))
		else $error("payload index ran past frame length");

	a_go_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		start.go |=> (ph_q == PH_HUNT && !s_tready))
		else $error("parser not back to hunting/stalled after good checksum");
`endif

endmodule
